[rtl/core/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, clocked on clock, off during reset
`define CHK_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication check
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/core/x86dec_pkg.sv]
// Package for the 8086 decoder: operand kinds, modes, phases, decode table.
// No dependencies.
`default_nettype none
package x86dec_pkg;
   localparam logic [2:0] MD_BAD = 3'd0, MD_OP = 3'd1, MD_GRP = 3'd2, MD_SEG = 3'd3,
      MD_PRE = 3'd4, MD_BCD = 3'd5, MD_ESC = 3'd6;
   localparam logic [5:0] KAL = 6'd0, KCL = 6'd1, KDL = 6'd2, KBL = 6'd3, KAH = 6'd4,
      KCH = 6'd5, KDH = 6'd6, KBH = 6'd7, KAX = 6'd8, KCX = 6'd9, KDX = 6'd10,
      KBX = 6'd11, KSP = 6'd12, KBP = 6'd13, KSI = 6'd14, KDI = 6'd15, KES = 6'd16,
      KCS = 6'd17, KSS = 6'd18, KDS = 6'd19, K1 = 6'd20, K3 = 6'd21, KIB = 6'd22,
      KIS = 6'd23, KJB = 6'd24, KIW = 6'd25, KAN = 6'd26, KMN = 6'd27, KAF = 6'd28,
      KRB = 6'd29, KRW = 6'd30, KRS = 6'd31, KEB = 6'd32, KEW = 6'd33, KNO = 6'd36;
   localparam logic [6:0] NBAD = 7'd0, NMOV = 7'd2, NXCHG = 7'd3, NXLAT = 7'd4,
      NPUSH = 7'd5, NPOP = 7'd6, NIN = 7'd7, NOUT = 7'd8, NLEA = 7'd9, NLDS = 7'd10,
      NLES = 7'd11, NLAHF = 7'd12, NSAHF = 7'd13, NPUSHF = 7'd14, NPOPF = 7'd15,
      NADD = 7'd16, NADC = 7'd17, NINC = 7'd18, NAAA = 7'd19, NDAA = 7'd20, NSUB = 7'd21,
      NSBB = 7'd22, NDEC = 7'd23, NNEG = 7'd24, NCMP = 7'd25, NAAS = 7'd26, NDAS = 7'd27,
      NMUL = 7'd28, NIMUL = 7'd29, NAAM = 7'd30, NDIV = 7'd31, NIDIV = 7'd32,
      NAAD = 7'd33, NCBW = 7'd34, NCWD = 7'd35, NNOT = 7'd36, NAND = 7'd37, NOR = 7'd38,
      NXOR = 7'd39, NTEST = 7'd40, NSHL = 7'd41, NSHR = 7'd42, NSAR = 7'd43,
      NROL = 7'd44, NROR = 7'd45, NRCL = 7'd46, NRCR = 7'd47, NREPZ = 7'd48,
      NREPNZ = 7'd49, NMOVSB = 7'd50, NCMPSB = 7'd51, NSCASB = 7'd52, NSTOSB = 7'd53,
      NLODSB = 7'd54, NMOVSW = 7'd55, NCMPSW = 7'd56, NSCASW = 7'd57, NSTOSW = 7'd58,
      NLODSW = 7'd59, NCALL = 7'd60, NCALLF = 7'd61, NRET = 7'd62, NRETF = 7'd63,
      NJMP = 7'd64, NJMPF = 7'd65, NJA = 7'd66, NJNB = 7'd67, NJB = 7'd68, NJBE = 7'd69,
      NJG = 7'd70, NJGE = 7'd71, NJL = 7'd72, NJLE = 7'd73, NJZ = 7'd74, NJNZ = 7'd75,
      NJO = 7'd76, NJNO = 7'd77, NJPE = 7'd78, NJPO = 7'd79, NJS = 7'd80, NJNS = 7'd81,
      NLOOP = 7'd82, NLOOPNZ = 7'd83, NLOOPZ = 7'd84, NJCXZ = 7'd85, NINT = 7'd86,
      NINTO = 7'd87, NIRET = 7'd88, NSTC = 7'd89, NCLC = 7'd90, NCMC = 7'd91,
      NSTD = 7'd92, NCLD = 7'd93, NSTI = 7'd94, NCLI = 7'd95, NHLT = 7'd96,
      NWAIT = 7'd97, NLOCK = 7'd98, NESC = 7'd99, NNOP = 7'd100, NSEG = 7'd1;
   localparam logic [3:0] P_OP = 4'd0, P_MODRM = 4'd1, P_BASE = 4'd2, P_DLO = 4'd3,
      P_DHI = 4'd4, P_ILO = 4'd5, P_IHI = 4'd6, P_SLO = 4'd7, P_SHI = 4'd8,
      P_END = 4'd9;
   localparam logic [1:0] SZ_BYTE = 2'd0, SZ_WORD = 2'd1, SZ_NONE = 2'd2;

   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] mn;
      logic [5:0] a1;
      logic [5:0] a2;
   } entry_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] mn;
      logic [5:0] a1;
      logic [5:0] a2;
      logic [1:0] dlen;
      logic [1:0] ilen;
      logic modrm;
      logic far;
   } dec_type;

   function automatic entry_type op_e(input logic [6:0] m, input logic [5:0] a,
                                      input logic [5:0] b);
      return '{MD_OP, m, a, b};
   endfunction

   function automatic logic [6:0] group_mn(input logic [1:0] g, input logic [2:0] r);
      logic [6:0] t0 [8];
      logic [6:0] t1 [8];
      logic [6:0] t2 [8];
      logic [6:0] t3 [8];
      t0 = '{NADD, NOR, NADC, NSBB, NAND, NSUB, NXOR, NCMP};
      t1 = '{NROL, NROR, NRCL, NRCR, NSHL, NSHR, NBAD, NSAR};
      t2 = '{NTEST, NBAD, NNOT, NNEG, NMUL, NIMUL, NDIV, NIDIV};
      t3 = '{NINC, NDEC, NCALL, NCALLF, NJMP, NJMPF, NPUSH, NBAD};
      case (g)
         2'd0: return t0[r];
         2'd1: return t1[r];
         2'd2: return t2[r];
         default: return t3[r];
      endcase
   endfunction

   function automatic entry_type optab(input logic [7:0] op);
      logic [6:0] alu [8];
      logic [6:0] jcc [16];
      entry_type e;
      alu = '{NADD, NOR, NADC, NSBB, NAND, NSUB, NXOR, NCMP};
      jcc = '{NJO, NJNO, NJB, NJNB, NJZ, NJNZ, NJBE, NJA,
              NJS, NJNS, NJPE, NJPO, NJL, NJGE, NJLE, NJG};
      e = '{MD_BAD, NBAD, KNO, KNO};
      if (op < 8'h40 && op[2:0] < 3'd6) begin
         case (op[2:0])
            3'd0: e = op_e(alu[op[5:3]], KEB, KRB);
            3'd1: e = op_e(alu[op[5:3]], KEW, KRW);
            3'd2: e = op_e(alu[op[5:3]], KRB, KEB);
            3'd3: e = op_e(alu[op[5:3]], KRW, KEW);
            3'd4: e = op_e(alu[op[5:3]], KAL, KIB);
            default: e = op_e(alu[op[5:3]], KAX, KIW);
         endcase
      end else if (op[7:4] == 4'h4) begin
         e = op_e(op[3] ? NDEC : NINC, {3'b001, op[2:0]}, KNO);
      end else if (op[7:4] == 4'h5) begin
         e = op_e(op[3] ? NPOP : NPUSH, {3'b001, op[2:0]}, KNO);
      end else if (op[7:4] == 4'h7) begin
         e = op_e(jcc[op[3:0]], KJB, KNO);
      end else if (op[7:4] == 4'hb) begin
         e = op_e(NMOV, op[3] ? {3'b001, op[2:0]} : {3'b000, op[2:0]}, op[3] ? KIW : KIB);
      end else if (op[7:3] == 5'b10010 && op[2:0] != 3'd0) begin
         e = op_e(NXCHG, {3'b001, op[2:0]}, KAX);
      end else if (op[7:3] == 5'b11011) begin
         e = '{MD_ESC, NESC, KNO, KEB};
      end else begin
         case (op)
            8'h06: e = op_e(NPUSH, KES, KNO);
            8'h07: e = op_e(NPOP, KES, KNO);
            8'h0e: e = op_e(NPUSH, KCS, KNO);
            8'h16: e = op_e(NPUSH, KSS, KNO);
            8'h17: e = op_e(NPOP, KSS, KNO);
            8'h1e: e = op_e(NPUSH, KDS, KNO);
            8'h1f: e = op_e(NPOP, KDS, KNO);
            8'h26: e = '{MD_SEG, {1'b0, KES}, KNO, KNO};
            8'h2e: e = '{MD_SEG, {1'b0, KCS}, KNO, KNO};
            8'h36: e = '{MD_SEG, {1'b0, KSS}, KNO, KNO};
            8'h3e: e = '{MD_SEG, {1'b0, KDS}, KNO, KNO};
            8'h27: e = op_e(NDAA, KNO, KNO);
            8'h2f: e = op_e(NDAS, KNO, KNO);
            8'h37: e = op_e(NAAA, KNO, KNO);
            8'h3f: e = op_e(NAAS, KNO, KNO);
            8'h80: e = '{MD_GRP, 7'd0, KEB, KIB};
            8'h81: e = '{MD_GRP, 7'd0, KEW, KIW};
            8'h82: e = '{MD_GRP, 7'd0, KEB, KIB};
            8'h83: e = '{MD_GRP, 7'd0, KEW, KIS};
            8'h84: e = op_e(NTEST, KRB, KEB);
            8'h85: e = op_e(NTEST, KRW, KEW);
            8'h86: e = op_e(NXCHG, KRB, KEB);
            8'h87: e = op_e(NXCHG, KRW, KEW);
            8'h88: e = op_e(NMOV, KEB, KRB);
            8'h89: e = op_e(NMOV, KEW, KRW);
            8'h8a: e = op_e(NMOV, KRB, KEB);
            8'h8b: e = op_e(NMOV, KRW, KEW);
            8'h8c: e = op_e(NMOV, KEW, KRS);
            8'h8d: e = op_e(NLEA, KRW, KEW);
            8'h8e: e = op_e(NMOV, KRS, KEW);
            8'h8f: e = op_e(NPOP, KEW, KNO);
            8'h90: e = op_e(NNOP, KNO, KNO);
            8'h98: e = op_e(NCBW, KNO, KNO);
            8'h99: e = op_e(NCWD, KNO, KNO);
            8'h9a: e = op_e(NCALL, KAF, KNO);
            8'h9b: e = op_e(NWAIT, KNO, KNO);
            8'h9c: e = op_e(NPUSHF, KNO, KNO);
            8'h9d: e = op_e(NPOPF, KNO, KNO);
            8'h9e: e = op_e(NSAHF, KNO, KNO);
            8'h9f: e = op_e(NLAHF, KNO, KNO);
            8'ha0: e = op_e(NMOV, KAL, KMN);
            8'ha1: e = op_e(NMOV, KAX, KMN);
            8'ha2: e = op_e(NMOV, KMN, KAL);
            8'ha3: e = op_e(NMOV, KMN, KAX);
            8'ha4: e = op_e(NMOVSB, KNO, KNO);
            8'ha5: e = op_e(NMOVSW, KNO, KNO);
            8'ha6: e = op_e(NCMPSB, KNO, KNO);
            8'ha7: e = op_e(NCMPSW, KNO, KNO);
            8'ha8: e = op_e(NTEST, KAL, KIB);
            8'ha9: e = op_e(NTEST, KAX, KIW);
            8'haa: e = op_e(NSTOSB, KNO, KNO);
            8'hab: e = op_e(NSTOSW, KNO, KNO);
            8'hac: e = op_e(NLODSB, KNO, KNO);
            8'had: e = op_e(NLODSW, KNO, KNO);
            8'hae: e = op_e(NSCASB, KNO, KNO);
            8'haf: e = op_e(NSCASW, KNO, KNO);
            8'hc2: e = op_e(NRET, KIW, KNO);
            8'hc3: e = op_e(NRET, KNO, KNO);
            8'hc4: e = op_e(NLES, KRW, KEW);
            8'hc5: e = op_e(NLDS, KRW, KEW);
            8'hc6: e = op_e(NMOV, KEB, KIB);
            8'hc7: e = op_e(NMOV, KEW, KIW);
            8'hca: e = op_e(NRETF, KIW, KNO);
            8'hcb: e = op_e(NRETF, KNO, KNO);
            8'hcc: e = op_e(NINT, K3, KNO);
            8'hcd: e = op_e(NINT, KIB, KNO);
            8'hce: e = op_e(NINTO, KNO, KNO);
            8'hcf: e = op_e(NIRET, KNO, KNO);
            8'hd0: e = '{MD_GRP, 7'd1, KEB, K1};
            8'hd1: e = '{MD_GRP, 7'd1, KEW, K1};
            8'hd2: e = '{MD_GRP, 7'd1, KEB, KCL};
            8'hd3: e = '{MD_GRP, 7'd1, KEW, KCL};
            8'hd4: e = '{MD_BCD, NAAM, KNO, KNO};
            8'hd5: e = '{MD_BCD, NAAD, KNO, KNO};
            8'hd7: e = op_e(NXLAT, KNO, KNO);
            8'he0: e = op_e(NLOOPNZ, KJB, KNO);
            8'he1: e = op_e(NLOOPZ, KJB, KNO);
            8'he2: e = op_e(NLOOP, KJB, KNO);
            8'he3: e = op_e(NJCXZ, KJB, KNO);
            8'he4: e = op_e(NIN, KAL, KIB);
            8'he5: e = op_e(NIN, KAX, KIB);
            8'he6: e = op_e(NOUT, KIB, KAL);
            8'he7: e = op_e(NOUT, KIB, KAX);
            8'he8: e = op_e(NCALL, KAN, KNO);
            8'he9: e = op_e(NJMP, KAN, KNO);
            8'hea: e = op_e(NJMP, KAF, KNO);
            8'heb: e = op_e(NJMP, KJB, KNO);
            8'hec: e = op_e(NIN, KAL, KDX);
            8'hed: e = op_e(NIN, KAX, KDX);
            8'hee: e = op_e(NOUT, KDX, KAL);
            8'hef: e = op_e(NOUT, KDX, KAX);
            8'hf0: e = '{MD_PRE, NLOCK, KNO, KNO};
            8'hf2: e = '{MD_PRE, NREPNZ, KNO, KNO};
            8'hf3: e = '{MD_PRE, NREPZ, KNO, KNO};
            8'hf4: e = op_e(NHLT, KNO, KNO);
            8'hf5: e = op_e(NCMC, KNO, KNO);
            8'hf6: e = '{MD_GRP, 7'd2, KEB, KNO};
            8'hf7: e = '{MD_GRP, 7'd2, KEW, KNO};
            8'hf8: e = op_e(NCLC, KNO, KNO);
            8'hf9: e = op_e(NSTC, KNO, KNO);
            8'hfa: e = op_e(NCLI, KNO, KNO);
            8'hfb: e = op_e(NSTI, KNO, KNO);
            8'hfc: e = op_e(NCLD, KNO, KNO);
            8'hfd: e = op_e(NSTD, KNO, KNO);
            8'hfe: e = '{MD_GRP, 7'd3, KEB, KNO};
            8'hff: e = '{MD_GRP, 7'd3, KEW, KNO};
            default: e = '{MD_BAD, NBAD, KNO, KNO};
         endcase
      end
      return e;
   endfunction

   function automatic logic is_modrm_kind(input logic [5:0] k);
      return k >= KRB && k <= KEW;
   endfunction

   function automatic dec_type decode(input logic [7:0] op, input logic [7:0] modrm);
      entry_type e;
      dec_type d;
      logic [5:0] ks [2];
      e = optab(op);
      d = '{e.mode, e.mn, e.a1, e.a2, 2'd0, 2'd0, 1'b0, 1'b0};
      if (e.mode == MD_GRP) begin
         if (op[7:1] == 7'h7b && modrm[5:3] == 3'd0) d.a2 = op[0] ? KIW : KIB;
         d.mn = group_mn(e.mn[1:0], modrm[5:3]);
      end
      d.modrm = e.mode == MD_GRP || e.mode == MD_ESC || is_modrm_kind(d.a1)
         || is_modrm_kind(d.a2);
      ks = '{d.a1, d.a2};
      for (int i = 0; i < 2; i++) begin
         if ((ks[i] == KEB || ks[i] == KEW) && modrm[7:6] != 2'd3) begin
            if (modrm[7:6] == 2'd1) d.dlen = 2'd1;
            else if (modrm[7:6] == 2'd2 || modrm[2:0] == 3'd6) d.dlen = 2'd2;
         end
         if (ks[i] == KMN) d.dlen = 2'd2;
         if (ks[i] == KIB || ks[i] == KIS || ks[i] == KJB) d.ilen = 2'd1;
         if (ks[i] == KIW || ks[i] == KAN || ks[i] == KAF) d.ilen = 2'd2;
         if (ks[i] == KAF) d.far = 1'b1;
      end
      return d;
   endfunction

   function automatic logic phase_used(input logic [3:0] p, input dec_type d);
      case (p)
         P_MODRM: return d.modrm;
         P_BASE: return d.mode == MD_BCD;
         P_DLO: return d.dlen >= 2'd1;
         P_DHI: return d.dlen == 2'd2;
         P_ILO: return d.ilen >= 2'd1;
         P_IHI: return d.ilen == 2'd2;
         P_SLO, P_SHI: return d.far;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [1:0] size_step(input logic [1:0] t, input logic [5:0] k,
                                            input logic [1:0] md);
      if (k == KIB || k == KJB) return SZ_BYTE;
      if (k == KIS || k == KIW || k == KAN || k == KMN || k == KAF) return SZ_WORD;
      if (k == KRB || k == KRW || k == KRS) return SZ_NONE;
      if (k == KEB || k == KEW) begin
         if (md == 2'd3) return SZ_NONE;
         if (t != SZ_NONE) return (k == KEW) ? SZ_WORD : SZ_BYTE;
      end
      return t;
   endfunction

   typedef struct packed {
      logic [15:0] instr_address;
      logic [7:0]  opcode;
      logic [6:0]  mnemonic_id;
      logic [5:0]  first_operand_kind;
      logic [5:0]  second_operand_kind;
      logic [1:0]  mod_field;
      logic [2:0]  reg_field;
      logic [2:0]  rm_field;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic [1:0]  size_mark;
      logic [15:0] branch_target;
   } record_type;
endpackage
`default_nettype wire

[rtl/core/x86_16bit_instruction_decoder_top.sv]
// Top level of the streaming 8086 instruction decoder.
// Usage:
//   req_ channel: one code byte per transaction (req_code_byte).
//   rsp_ channel: one decoded record per complete instruction.
//   csr_ channel: start address; loads the address counter and drops any
//   partial instruction. Write only while idle.
// Throughput: one byte per cycle while req_ready is high. On the last byte
// the record goes to the result register, or the skid entry on a stall;
// table decode and field assembly sit between holding and result registers.
// Reset: address counter 0, decoder expects an opcode, no record pending.
// Stall: a result register plus one skid entry absorb a stalled receiver;
// req_ready drops when the skid entry is full and during a csr_ write.
// csr_ready is always high.
`default_nettype none
module x86_16bit_instruction_decoder_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [15:0] csr_start_address,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_code_byte,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [15:0] rsp_instr_address,
   output logic [7:0]  rsp_opcode,
   output logic [6:0]  rsp_mnemonic_id,
   output logic [5:0]  rsp_first_operand_kind,
   output logic [5:0]  rsp_second_operand_kind,
   output logic [1:0]  rsp_mod_field,
   output logic [2:0]  rsp_reg_field,
   output logic [2:0]  rsp_rm_field,
   output logic [15:0] rsp_displacement,
   output logic [15:0] rsp_immediate,
   output logic [1:0]  rsp_size_mark,
   output logic [15:0] rsp_branch_target
);
   import x86dec_pkg::*;

   record_type rec, orec;
   logic rec_valid, space, step;

   assign csr_ready = 1'b1;
   assign req_ready = space && !csr_valid;
   assign step = req_valid && req_ready;

   x86dec_front u_front (
      .clock(clock), .reset(reset), .csr_valid(csr_valid),
      .csr_start_address(csr_start_address), .step(step),
      .code_byte(req_code_byte), .rec(rec), .rec_valid(rec_valid)
   );

   x86dec_outreg u_out (
      .clock(clock), .reset(reset), .in_valid(rec_valid), .in_rec(rec),
      .space(space), .out_valid(rsp_valid), .out_ready(rsp_ready), .out_rec(orec)
   );

   assign rsp_instr_address = orec.instr_address;
   assign rsp_opcode = orec.opcode;
   assign rsp_mnemonic_id = orec.mnemonic_id;
   assign rsp_first_operand_kind = orec.first_operand_kind;
   assign rsp_second_operand_kind = orec.second_operand_kind;
   assign rsp_mod_field = orec.mod_field;
   assign rsp_reg_field = orec.reg_field;
   assign rsp_rm_field = orec.rm_field;
   assign rsp_displacement = orec.displacement;
   assign rsp_immediate = orec.immediate;
   assign rsp_size_mark = orec.size_mark;
   assign rsp_branch_target = orec.branch_target;
endmodule
`default_nettype wire

[rtl/core/x86dec_front.sv]
// Byte assembler: phase machine and instruction holding registers.
// Depends on x86dec_pkg and assert_macros.svh.
`default_nettype none
module x86dec_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_valid,
   input  wire logic [15:0] csr_start_address,
   input  wire logic step,
   input  wire logic [7:0] code_byte,
   output x86dec_pkg::record_type rec,
   output logic rec_valid
);
   import x86dec_pkg::*;
   `include "assert_macros.svh"

   logic [15:0] addr_ff, addr_in, start_ff, start_in, disp_ff, disp_in, imm_ff, imm_in;
   logic [3:0]  phase_ff, phase_in, p, pn;
   logic [7:0]  op_ff, op_in, modrm_ff, modrm_in;
   logic        first;
   dec_type     d;
   logic [1:0]  t;
   logic [5:0]  k1, k2;
   logic [6:0]  mn;

   always_comb begin
      first = phase_ff == P_OP || phase_ff >= P_END;
      p = first ? P_OP : phase_ff;
      start_in = first ? addr_ff : start_ff;
      op_in = first ? code_byte : op_ff;
      modrm_in = first ? 8'd0 : modrm_ff;
      disp_in = first ? 16'd0 : disp_ff;
      imm_in = first ? 16'd0 : imm_ff;
      d = decode(op_in, modrm_in);
      case (p)
         P_MODRM: modrm_in = code_byte;
         P_BASE: imm_in = {8'd0, code_byte};
         P_DLO: disp_in = d.dlen == 2'd1 ? {{8{code_byte[7]}}, code_byte}
                                        : {8'd0, code_byte};
         P_DHI, P_SHI: disp_in = {code_byte, disp_in[7:0]};
         P_ILO: imm_in = d.ilen == 2'd1 ? {{8{code_byte[7]}}, code_byte}
                                       : {8'd0, code_byte};
         P_IHI: imm_in = {code_byte, imm_in[7:0]};
         P_SLO: disp_in = {8'd0, code_byte};
         default: ;
      endcase
      addr_in = addr_ff + 16'd1;
      d = decode(op_in, modrm_in);
      pn = P_END;
      for (int q = 8; q >= 1; q--) begin
         if (q[3:0] > p && phase_used(q[3:0], d)) pn = q[3:0];
      end
      phase_in = (pn == P_END) ? P_OP : pn;
      t = (d.mode == MD_ESC) ? SZ_NONE : SZ_BYTE;
      t = size_step(t, d.a1, modrm_in[7:6]);
      t = size_step(t, d.a2, modrm_in[7:6]);
      if (op_in == 8'h8f || (op_in[7:1] == 7'h7f && modrm_in[5:3] >= 3'd2)) t = SZ_NONE;
      mn = d.mn;
      k1 = d.a1;
      k2 = d.a2;
      if (d.mode == MD_SEG) begin
         mn = NSEG;
         k1 = d.mn[5:0];
         k2 = KNO;
      end
      if (d.mode == MD_BAD) begin
         mn = NBAD;
         k1 = KNO;
         k2 = KNO;
      end
      rec.instr_address = start_in;
      rec.opcode = op_in;
      rec.mnemonic_id = mn;
      rec.first_operand_kind = k1;
      rec.second_operand_kind = k2;
      rec.mod_field = modrm_in[7:6];
      rec.reg_field = modrm_in[5:3];
      rec.rm_field = modrm_in[2:0];
      rec.displacement = disp_in;
      rec.immediate = imm_in;
      rec.size_mark = t;
      rec.branch_target = (k1 == KJB || k1 == KAN || k2 == KJB || k2 == KAN)
         ? addr_in + imm_in : 16'd0;
      rec_valid = step && pn == P_END;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= 16'd0;
         phase_ff <= P_OP;
      end else if (csr_valid) begin
         addr_ff <= csr_start_address;
         phase_ff <= P_OP;
      end else if (step) begin
         addr_ff <= addr_in;
         phase_ff <= phase_in;
      end
      if (!reset && !csr_valid && step) begin
         start_ff <= start_in;
         op_ff <= op_in;
         modrm_ff <= modrm_in;
         disp_ff <= disp_in;
         imm_ff <= imm_in;
      end
   end

   `CHK_IMPL(a_phase_range, 1'b1, phase_ff < P_END, "phase out of range")
   `CHK_NEXT(a_addr_step, step && !csr_valid, addr_ff == $past(addr_ff) + 16'd1,
      "address did not advance")
   `CHK_NEXT(a_csr_phase, csr_valid, phase_ff == P_OP, "config did not restart")
endmodule
`default_nettype wire

[rtl/core/x86dec_outreg.sv]
// Result register with skid stage on the response channel.
// Depends on x86dec_pkg and assert_macros.svh.
`default_nettype none
module x86dec_outreg (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  x86dec_pkg::record_type in_rec,
   output logic space,
   output logic out_valid,
   input  wire logic out_ready,
   output x86dec_pkg::record_type out_rec
);
   import x86dec_pkg::*;
   `include "assert_macros.svh"

   logic main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   record_type main_ff, skid_ff;

   assign space = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_rec = main_ff;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      if (!main_v_ff || out_ready) begin
         main_v_in = skid_v_ff || in_valid;
         skid_v_in = 1'b0;
      end else if (in_valid) begin
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      if (!main_v_ff || out_ready) main_ff <= skid_v_ff ? skid_ff : in_rec;
      else if (in_valid) skid_ff <= in_rec;
   end

   `CHK_IMPL(a_skid_main, skid_v_ff, main_v_ff, "skid full with main empty")
   `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule
`default_nettype wire

[sim/tb_x86_16bit_instruction_decoder_top.sv]
// Self-checking testbench for the streaming 8086 decoder top level.
// Needs x86dec_pkg for operand kinds, mnemonic codes, phases and the record type.
// Bytes go in over req_; rsp_ records are checked against a predictor or directed rows.
`timescale 1ns / 100ps
module tb_x86_16bit_instruction_decoder_top;
   import x86dec_pkg::*;

   typedef struct {
      logic [2:0] mode;
      logic [6:0] mn;
      logic [5:0] k1;
      logic [5:0] k2;
      logic [1:0] dlen;
      logic [1:0] ilen;
      bit         has_modrm;
      bit         far;
   } op_shape_type;

   typedef struct {
      logic [7:0] code;
      bit         typed;
      record_type rec;
   } stim_row_type;

   localparam int IDLE_PCT = 18;
   localparam int HOLD_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_BYTES = 330;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_start_address = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_code_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   record_type rsp;

   x86_16bit_instruction_decoder_top u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_start_address(csr_start_address),
      .req_valid(req_valid), .req_ready(req_ready), .req_code_byte(req_code_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_instr_address(rsp.instr_address), .rsp_opcode(rsp.opcode),
      .rsp_mnemonic_id(rsp.mnemonic_id),
      .rsp_first_operand_kind(rsp.first_operand_kind),
      .rsp_second_operand_kind(rsp.second_operand_kind),
      .rsp_mod_field(rsp.mod_field), .rsp_reg_field(rsp.reg_field),
      .rsp_rm_field(rsp.rm_field), .rsp_displacement(rsp.displacement),
      .rsp_immediate(rsp.immediate), .rsp_size_mark(rsp.size_mark),
      .rsp_branch_target(rsp.branch_target)
   );

   always #6 clock = ~clock;

   // decoder shadow state
   logic [15:0] addr_ctr;
   logic [3:0]  phase;
   logic [7:0]  op_h;
   logic [7:0]  mrm_h;
   logic [15:0] disp_h;
   logic [15:0] imm_h;
   logic [15:0] start_h;

   record_type   pending_records[$];
   stim_row_type directed[$];
   int  errors = 0;
   int  n_bytes = 0;
   int  n_records = 0;
   int  n_csr = 0;
   int  idle_cycles = 0;
   int  hold_cnt = 0;
   bit  hold_go = 0;
   bit  no_idle = 0;

   function automatic logic [6:0] group_name(input logic [1:0] g, input logic [2:0] r);
      case (g)
         2'd0: case (r)
            3'd0: return NADD;  3'd1: return NOR;  3'd2: return NADC; 3'd3: return NSBB;
            3'd4: return NAND;  3'd5: return NSUB; 3'd6: return NXOR; default: return NCMP;
         endcase
         2'd1: case (r)
            3'd0: return NROL;  3'd1: return NROR; 3'd2: return NRCL; 3'd3: return NRCR;
            3'd4: return NSHL;  3'd5: return NSHR; 3'd6: return NBAD; default: return NSAR;
         endcase
         2'd2: case (r)
            3'd0: return NTEST; 3'd1: return NBAD; 3'd2: return NNOT; 3'd3: return NNEG;
            3'd4: return NMUL;  3'd5: return NIMUL; 3'd6: return NDIV; default: return NIDIV;
         endcase
         default: case (r)
            3'd0: return NINC;  3'd1: return NDEC; 3'd2: return NCALL; 3'd3: return NCALLF;
            3'd4: return NJMP;  3'd5: return NJMPF; 3'd6: return NPUSH; default: return NBAD;
         endcase
      endcase
   endfunction

   function automatic logic [6:0] jcc_name(input logic [3:0] c);
      case (c)
         4'h0: return NJO;  4'h1: return NJNO; 4'h2: return NJB;  4'h3: return NJNB;
         4'h4: return NJZ;  4'h5: return NJNZ; 4'h6: return NJBE; 4'h7: return NJA;
         4'h8: return NJS;  4'h9: return NJNS; 4'ha: return NJPE; 4'hb: return NJPO;
         4'hc: return NJL;  4'hd: return NJGE; 4'he: return NJLE; default: return NJG;
      endcase
   endfunction

   function automatic entry_type opcode_row(input logic [7:0] op);
      entry_type r;
      r = '{MD_OP, NBAD, KNO, KNO};
      if (op < 8'h40) begin
         r.mn = group_name(2'd0, op[5:3]);
         case (op[2:0])
            3'd0: begin r.a1 = KEB; r.a2 = KRB; end
            3'd1: begin r.a1 = KEW; r.a2 = KRW; end
            3'd2: begin r.a1 = KRB; r.a2 = KEB; end
            3'd3: begin r.a1 = KRW; r.a2 = KEW; end
            3'd4: begin r.a1 = KAL; r.a2 = KIB; end
            3'd5: begin r.a1 = KAX; r.a2 = KIW; end
            3'd6: begin
               if (op[5]) r = '{MD_SEG, {1'b0, KES + 6'(op[4:3])}, KNO, KNO};
               else r = '{MD_OP, NPUSH, KES + 6'(op[4:3]), KNO};
            end
            default: begin
               if (op[5]) case (op[4:3])
                  2'd0: r = '{MD_OP, NDAA, KNO, KNO};
                  2'd1: r = '{MD_OP, NDAS, KNO, KNO};
                  2'd2: r = '{MD_OP, NAAA, KNO, KNO};
                  default: r = '{MD_OP, NAAS, KNO, KNO};
               endcase
               else if (op == 8'h0f) r = '{MD_BAD, NBAD, KNO, KNO};
               else r = '{MD_OP, NPOP, KES + 6'(op[4:3]), KNO};
            end
         endcase
         return r;
      end
      case (op[7:4])
         4'h4: r = '{MD_OP, op[3] ? NDEC : NINC, KAX + 6'(op[2:0]), KNO};
         4'h5: r = '{MD_OP, op[3] ? NPOP : NPUSH, KAX + 6'(op[2:0]), KNO};
         4'h7: r = '{MD_OP, jcc_name(op[3:0]), KJB, KNO};
         4'hb: r = op[3] ? '{MD_OP, NMOV, KAX + 6'(op[2:0]), KIW}
                         : '{MD_OP, NMOV, KAL + 6'(op[2:0]), KIB};
         4'h8: case (op[3:0])
            4'h0, 4'h2: r = '{MD_GRP, 7'd0, KEB, KIB};
            4'h1: r = '{MD_GRP, 7'd0, KEW, KIW};
            4'h3: r = '{MD_GRP, 7'd0, KEW, KIS};
            4'h4: r = '{MD_OP, NTEST, KRB, KEB};
            4'h5: r = '{MD_OP, NTEST, KRW, KEW};
            4'h6: r = '{MD_OP, NXCHG, KRB, KEB};
            4'h7: r = '{MD_OP, NXCHG, KRW, KEW};
            4'h8: r = '{MD_OP, NMOV, KEB, KRB};
            4'h9: r = '{MD_OP, NMOV, KEW, KRW};
            4'ha: r = '{MD_OP, NMOV, KRB, KEB};
            4'hb: r = '{MD_OP, NMOV, KRW, KEW};
            4'hc: r = '{MD_OP, NMOV, KEW, KRS};
            4'hd: r = '{MD_OP, NLEA, KRW, KEW};
            4'he: r = '{MD_OP, NMOV, KRS, KEW};
            default: r = '{MD_OP, NPOP, KEW, KNO};
         endcase
         4'h9: case (op[3:0])
            4'h0: r = '{MD_OP, NNOP, KNO, KNO};
            4'h8: r = '{MD_OP, NCBW, KNO, KNO};
            4'h9: r = '{MD_OP, NCWD, KNO, KNO};
            4'ha: r = '{MD_OP, NCALL, KAF, KNO};
            4'hb: r = '{MD_OP, NWAIT, KNO, KNO};
            4'hc: r = '{MD_OP, NPUSHF, KNO, KNO};
            4'hd: r = '{MD_OP, NPOPF, KNO, KNO};
            4'he: r = '{MD_OP, NSAHF, KNO, KNO};
            4'hf: r = '{MD_OP, NLAHF, KNO, KNO};
            default: r = '{MD_OP, NXCHG, KAX + 6'(op[2:0]), KAX};
         endcase
         4'ha: case (op[3:0])
            4'h0: r = '{MD_OP, NMOV, KAL, KMN};
            4'h1: r = '{MD_OP, NMOV, KAX, KMN};
            4'h2: r = '{MD_OP, NMOV, KMN, KAL};
            4'h3: r = '{MD_OP, NMOV, KMN, KAX};
            4'h4: r.mn = NMOVSB;  4'h5: r.mn = NMOVSW;
            4'h6: r.mn = NCMPSB;  4'h7: r.mn = NCMPSW;
            4'h8: r = '{MD_OP, NTEST, KAL, KIB};
            4'h9: r = '{MD_OP, NTEST, KAX, KIW};
            4'ha: r.mn = NSTOSB;  4'hb: r.mn = NSTOSW;
            4'hc: r.mn = NLODSB;  4'hd: r.mn = NLODSW;
            4'he: r.mn = NSCASB;  default: r.mn = NSCASW;
         endcase
         4'hc: case (op[3:0])
            4'h2: r = '{MD_OP, NRET, KIW, KNO};
            4'h3: r.mn = NRET;
            4'h4: r = '{MD_OP, NLES, KRW, KEW};
            4'h5: r = '{MD_OP, NLDS, KRW, KEW};
            4'h6: r = '{MD_OP, NMOV, KEB, KIB};
            4'h7: r = '{MD_OP, NMOV, KEW, KIW};
            4'ha: r = '{MD_OP, NRETF, KIW, KNO};
            4'hb: r.mn = NRETF;
            4'hc: r = '{MD_OP, NINT, K3, KNO};
            4'hd: r = '{MD_OP, NINT, KIB, KNO};
            4'he: r.mn = NINTO;
            4'hf: r.mn = NIRET;
            default: r.mode = MD_BAD;
         endcase
         4'hd: begin
            if (op[3]) r = '{MD_ESC, NESC, KNO, KEB};
            else case (op[2:0])
               3'd4: r = '{MD_BCD, NAAM, KNO, KNO};
               3'd5: r = '{MD_BCD, NAAD, KNO, KNO};
               3'd6: r.mode = MD_BAD;
               3'd7: r.mn = NXLAT;
               default: r = '{MD_GRP, 7'd1, op[0] ? KEW : KEB, op[1] ? KCL : K1};
            endcase
         end
         4'he: case (op[3:0])
            4'h0: r = '{MD_OP, NLOOPNZ, KJB, KNO};
            4'h1: r = '{MD_OP, NLOOPZ, KJB, KNO};
            4'h2: r = '{MD_OP, NLOOP, KJB, KNO};
            4'h3: r = '{MD_OP, NJCXZ, KJB, KNO};
            4'h4: r = '{MD_OP, NIN, KAL, KIB};
            4'h5: r = '{MD_OP, NIN, KAX, KIB};
            4'h6: r = '{MD_OP, NOUT, KIB, KAL};
            4'h7: r = '{MD_OP, NOUT, KIB, KAX};
            4'h8: r = '{MD_OP, NCALL, KAN, KNO};
            4'h9: r = '{MD_OP, NJMP, KAN, KNO};
            4'ha: r = '{MD_OP, NJMP, KAF, KNO};
            4'hb: r = '{MD_OP, NJMP, KJB, KNO};
            4'hc: r = '{MD_OP, NIN, KAL, KDX};
            4'hd: r = '{MD_OP, NIN, KAX, KDX};
            4'he: r = '{MD_OP, NOUT, KDX, KAL};
            default: r = '{MD_OP, NOUT, KDX, KAX};
         endcase
         4'hf: case (op[3:0])
            4'h0: r = '{MD_PRE, NLOCK, KNO, KNO};
            4'h2: r = '{MD_PRE, NREPNZ, KNO, KNO};
            4'h3: r = '{MD_PRE, NREPZ, KNO, KNO};
            4'h4: r.mn = NHLT;
            4'h5: r.mn = NCMC;
            4'h6: r = '{MD_GRP, 7'd2, KEB, KNO};
            4'h7: r = '{MD_GRP, 7'd2, KEW, KNO};
            4'h8: r.mn = NCLC;  4'h9: r.mn = NSTC;
            4'ha: r.mn = NCLI;  4'hb: r.mn = NSTI;
            4'hc: r.mn = NCLD;  4'hd: r.mn = NSTD;
            4'he: r = '{MD_GRP, 7'd3, KEB, KNO};
            4'hf: r = '{MD_GRP, 7'd3, KEW, KNO};
            default: r.mode = MD_BAD;
         endcase
         default: r.mode = MD_BAD;
      endcase
      return r;
   endfunction

   function automatic op_shape_type shape_of(input logic [7:0] op, input logic [7:0] mrm);
      entry_type e;
      op_shape_type s;
      logic [5:0] k;
      e = opcode_row(op);
      s = '{e.mode, e.mn, e.a1, e.a2, 2'd0, 2'd0, 1'b0, 1'b0};
      if (e.mode == MD_GRP) begin
         if (op[7:1] == 7'b1111011 && mrm[5:3] == 3'd0) s.k2 = op[0] ? KIW : KIB;
         s.mn = group_name(e.mn[1:0], mrm[5:3]);
      end
      s.has_modrm = e.mode == MD_GRP || e.mode == MD_ESC
         || (s.k1 >= KRB && s.k1 <= KEW) || (s.k2 >= KRB && s.k2 <= KEW);
      for (int i = 0; i < 2; i++) begin
         k = i ? s.k2 : s.k1;
         if ((k == KEB || k == KEW) && mrm[7:6] != 2'd3) begin
            if (mrm[7:6] == 2'd1) s.dlen = 2'd1;
            else if (mrm[7:6] == 2'd2 || mrm[2:0] == 3'd6) s.dlen = 2'd2;
         end
         if (k == KMN) s.dlen = 2'd2;
         if (k == KIB || k == KIS || k == KJB) s.ilen = 2'd1;
         if (k == KIW || k == KAN || k == KAF) s.ilen = 2'd2;
         if (k == KAF) s.far = 1'b1;
      end
      return s;
   endfunction

   function automatic bit phase_needed(input logic [3:0] p, input op_shape_type s);
      case (p)
         P_MODRM: return s.has_modrm;
         P_BASE: return s.mode == MD_BCD;
         P_DLO: return s.dlen != 2'd0;
         P_DHI: return s.dlen == 2'd2;
         P_ILO: return s.ilen != 2'd0;
         P_IHI: return s.ilen == 2'd2;
         P_SLO, P_SHI: return s.far;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [1:0] size_after(input logic [1:0] t, input logic [5:0] k,
                                             input logic [1:0] md);
      if (k == KIB || k == KJB) return SZ_BYTE;
      if (k == KIS || k == KIW || k == KAN || k == KMN || k == KAF) return SZ_WORD;
      if (k == KRB || k == KRW || k == KRS) return SZ_NONE;
      if ((k == KEB || k == KEW) && md == 2'd3) return SZ_NONE;
      if ((k == KEB || k == KEW) && t != SZ_NONE) return (k == KEW) ? SZ_WORD : SZ_BYTE;
      return t;
   endfunction

   task automatic decode_byte(input logic [7:0] b, output bit done, output record_type r);
      op_shape_type s;
      logic [3:0] p;
      logic [1:0] t;
      p = phase;
      if (p == P_OP) begin
         start_h = addr_ctr;
         op_h = b;
         mrm_h = '0;
         disp_h = '0;
         imm_h = '0;
      end
      s = shape_of(op_h, mrm_h);
      case (p)
         P_MODRM: mrm_h = b;
         P_BASE: imm_h = {8'h00, b};
         P_DLO: disp_h = s.dlen == 2'd1 ? {{8{b[7]}}, b} : {8'h00, b};
         P_ILO: imm_h = s.ilen == 2'd1 ? {{8{b[7]}}, b} : {8'h00, b};
         P_SLO: disp_h = {8'h00, b};
         P_DHI, P_SHI: disp_h[15:8] = b;
         P_IHI: imm_h[15:8] = b;
         default: ;
      endcase
      addr_ctr = addr_ctr + 16'd1;
      s = shape_of(op_h, mrm_h);
      p = p + 4'd1;
      while (p < P_END && !phase_needed(p, s)) p = p + 4'd1;
      done = p >= P_END;
      r = '0;
      if (!done) begin
         phase = p;
         return;
      end
      phase = P_OP;
      t = s.mode == MD_ESC ? SZ_NONE : SZ_BYTE;
      t = size_after(t, s.k1, mrm_h[7:6]);
      t = size_after(t, s.k2, mrm_h[7:6]);
      if (op_h == 8'h8f || (op_h[7:1] == 7'h7f && mrm_h[5:3] >= 3'd2)) t = SZ_NONE;
      r.mnemonic_id = s.mn;
      r.first_operand_kind = s.k1;
      r.second_operand_kind = s.k2;
      if (s.mode == MD_SEG) begin
         r.mnemonic_id = NSEG;
         r.first_operand_kind = s.mn[5:0];
         r.second_operand_kind = KNO;
      end
      if (s.mode == MD_BAD) begin
         r.mnemonic_id = NBAD;
         r.first_operand_kind = KNO;
         r.second_operand_kind = KNO;
      end
      r.instr_address = start_h;
      r.opcode = op_h;
      r.mod_field = mrm_h[7:6];
      r.reg_field = mrm_h[5:3];
      r.rm_field = mrm_h[2:0];
      r.displacement = disp_h;
      r.immediate = imm_h;
      r.size_mark = t;
      if (r.first_operand_kind inside {KJB, KAN} || r.second_operand_kind inside {KJB, KAN})
         r.branch_target = addr_ctr + imm_h;
   endtask

   task automatic send_byte(input stim_row_type row);
      bit done;
      record_type r;
      req_valid <= 1'b1;
      req_code_byte <= row.code;
      do @(posedge clock); while (!req_ready);
      n_bytes++;
      decode_byte(row.code, done, r);
      if (done) pending_records.push_back(row.typed ? row.rec : r);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic load_start(input logic [15:0] a);
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_start_address <= a;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_csr++;
      addr_ctr = a;
      phase = P_OP;
   endtask

   task automatic cmp_field(input string name, input logic [15:0] exp_v,
                            input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      record_type e;
      if (rsp_valid && rsp_ready) begin
         n_records++;
         if (pending_records.size() == 0) begin
            errors++;
            $display("%0t: unexpected record expected none actual %p", $realtime, rsp);
         end else begin
            e = pending_records.pop_front();
            cmp_field("instr_address", e.instr_address, rsp.instr_address);
            cmp_field("opcode", 16'(e.opcode), 16'(rsp.opcode));
            cmp_field("mnemonic_id", 16'(e.mnemonic_id), 16'(rsp.mnemonic_id));
            cmp_field("first_operand_kind", 16'(e.first_operand_kind),
                      16'(rsp.first_operand_kind));
            cmp_field("second_operand_kind", 16'(e.second_operand_kind),
                      16'(rsp.second_operand_kind));
            cmp_field("mod_field", 16'(e.mod_field), 16'(rsp.mod_field));
            cmp_field("reg_field", 16'(e.reg_field), 16'(rsp.reg_field));
            cmp_field("rm_field", 16'(e.rm_field), 16'(rsp.rm_field));
            cmp_field("displacement", e.displacement, rsp.displacement);
            cmp_field("immediate", e.immediate, rsp.immediate);
            cmp_field("size_mark", 16'(e.size_mark), 16'(rsp.size_mark));
            cmp_field("branch_target", e.branch_target, rsp.branch_target);
         end
      end
      if (hold_go) begin
         hold_go = 0;
         hold_cnt = HOLD_CYCLES;
      end
      if (reset) rsp_ready <= 1'b0;
      else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else rsp_ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic [15:0] starts [4];
      logic [7:0] codes [25];
      addr_ctr = '0;
      phase = P_OP;
      op_h = '0;
      mrm_h = '0;
      disp_h = '0;
      imm_h = '0;
      start_h = '0;
      // undefined opcode, segment override, then operand-heavy forms
      directed.push_back('{8'h0f, 1'b1,
         '{16'h0000, 8'h0f, NBAD, KNO, KNO, 2'd0, 3'd0, 3'd0, 16'h0, 16'h0, SZ_BYTE, 16'h0}});
      directed.push_back('{8'h26, 1'b1,
         '{16'h0001, 8'h26, NSEG, KES, KNO, 2'd0, 3'd0, 3'd0, 16'h0, 16'h0, SZ_BYTE, 16'h0}});
      codes = '{8'hf6, 8'hc0, 8'h7f, 8'hd4, 8'h0a, 8'hdf, 8'hff, 8'h9a, 8'h00, 8'h00,
                8'hff, 8'hff, 8'h70, 8'h80, 8'hfe, 8'hf8, 8'h8f, 8'h00, 8'hf7, 8'h06,
                8'h01, 8'h80, 8'hff, 8'h7f, 8'h05};
      foreach (codes[i]) directed.push_back('{codes[i], 1'b0, '0});
      starts = '{16'h0000, 16'hffff, 16'h7ffe, 16'($urandom)};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_start(starts[0]);
      foreach (directed[i]) send_byte(directed[i]);
      // last directed byte leaves an instruction open; the write must drop it
      for (int ph = 1; ph < 4; ph++) begin
         load_start(starts[ph]);
         no_idle = ph == 2;
         for (int n = 0; n < RANDOM_BYTES; n++) begin
            if (ph == 1 && n == 20) hold_go = 1;
            row = '{8'($urandom), 1'b0, '0};
            send_byte(row);
         end
      end
      req_valid <= 1'b0;
      no_idle = 0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES + 2) @(posedge clock);
      $display("Covered %0d code bytes, %0d decoded records, %0d start address loads.",
               n_bytes, n_records, n_csr);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
